>>> rtl/kfs_pkg.sv
// Shared types, constants and helpers for the keyframe track sampler.
package kfs_pkg;

   localparam int MAX_KEYS_DEF = 64;
   localparam int SLOT_W       = 6;
   localparam int COUNT_W      = 7;
   localparam int WORD_W       = 32;
   localparam int FRAC_W       = 16;
   localparam int DIVIDEND_W   = WORD_W + FRAC_W;

   typedef enum logic {
      KIND_LOAD  = 1'b0,
      KIND_QUERY = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_ZERO_SPAN = 2'd1,
      STAT_EMPTY     = 2'd2
   } status_type;

   // One stored key: time and three components (components are signed Q16.16)
   typedef struct packed {
      logic [WORD_W-1:0] ktime;
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] z;
   } key_type;

   // Classified beat handed from front to back; for a query ktime is the sample time
   typedef struct packed {
      kind_type          kind;
      logic              slot_ok;
      logic [SLOT_W-1:0] slot;
      key_type           key;
   } cmd_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [WORD_W-1:0]     divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RD_A,
      ST_RD_B,
      ST_GET_B,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_MUL,
      ST_FIN,
      ST_EMIT
   } back_state_type;

   // Clamp a wide signed value to signed 32 bits
   function automatic logic [WORD_W-1:0] sat_word(input logic signed [49:0] v);
      logic [WORD_W-1:0] r;
      if (v > 50'sh7FFF_FFFF) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -50'sh8000_0000) begin
         r = 32'h8000_0000;
      end else begin
         r = v[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/kfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kfs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/kfs_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module kfs_div (
   input  logic                 clock,
   input  logic                 reset,
   input  kfs_pkg::div_req_type req,
   output kfs_pkg::div_rsp_type rsp
);

   localparam int NW = kfs_pkg::DIVIDEND_W;
   localparam int DW = kfs_pkg::WORD_W;
   localparam int CW = $clog2(NW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] num_ff, num_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   rem_sh;
   logic [DW:0]   rem_sub;
   logic          ge;

   // one compare/subtract step; numerator shifts out, quotient shifts in
   always_comb begin
      rem_sh  = {rem_ff, num_ff[NW-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NW);
         num_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[NW-2:0], ge};
         rem_in = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = num_ff;

endmodule

>>> rtl/kfs_front.sv
// Front end: accepts request beats, classifies them and queues them for the back end.
module kfs_front #(
   parameter int MAX_KEYS = kfs_pkg::MAX_KEYS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic                         req_kind,
   input  logic [kfs_pkg::SLOT_W-1:0]   req_key_slot,
   input  logic [kfs_pkg::WORD_W-1:0]   req_key_time,
   input  logic [kfs_pkg::WORD_W-1:0]   req_key_x,
   input  logic [kfs_pkg::WORD_W-1:0]   req_key_y,
   input  logic [kfs_pkg::WORD_W-1:0]   req_key_z,
   input  logic [kfs_pkg::WORD_W-1:0]   req_sample_time,
   output logic                         cmd_valid,
   output kfs_pkg::cmd_type             cmd,
   input  logic                         cmd_pop
);

   kfs_pkg::cmd_type q_ff [2];
   kfs_pkg::cmd_type new_cmd;
   logic             wp_ff, wp_in;
   logic             rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push_ok;
   logic             pop_ok;

   // classify: loads keep their key, queries carry the sample time
   always_comb begin
      new_cmd.kind    = kfs_pkg::kind_type'(req_kind);
      new_cmd.slot    = req_key_slot;
      new_cmd.slot_ok = int'(req_key_slot) < MAX_KEYS;
      new_cmd.key.x   = req_key_x;
      new_cmd.key.y   = req_key_y;
      new_cmd.key.z   = req_key_z;
      if (new_cmd.kind == kfs_pkg::KIND_QUERY) begin
         new_cmd.key.ktime = req_sample_time;
      end else begin
         new_cmd.key.ktime = req_key_time;
      end
   end

   // two-entry queue pointers
   assign req_full  = cnt_ff == 2'd2;
   assign cmd_valid = cnt_ff != 2'd0;
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;
   assign cmd       = q_ff[rp_ff];

   always_comb begin
      wp_in  = push_ok ? !wp_ff : wp_ff;
      rp_in  = pop_ok ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push_ok) begin
         q_ff[wp_ff] <= new_cmd;
      end
   end

endmodule

>>> rtl/kfs_back.sv
// Back end: key table, segment scan, span division, interpolation and result register.
module kfs_back #(
   parameter int MAX_KEYS = kfs_pkg::MAX_KEYS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [kfs_pkg::COUNT_W-1:0] key_count,
   input  logic                        cmd_valid,
   input  kfs_pkg::cmd_type            cmd,
   output logic                        cmd_pop,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [kfs_pkg::WORD_W-1:0]  rsp_out_x,
   output logic [kfs_pkg::WORD_W-1:0]  rsp_out_y,
   output logic [kfs_pkg::WORD_W-1:0]  rsp_out_z,
   output logic [1:0]                  rsp_status
);

   localparam int AW  = $clog2(MAX_KEYS);
   localparam int CW  = AW + 1;
   localparam int NW  = (kfs_pkg::COUNT_W > CW) ? kfs_pkg::COUNT_W : CW;
   localparam int W   = kfs_pkg::WORD_W;
   localparam int KW  = $bits(kfs_pkg::key_type);

   kfs_pkg::back_state_type state_ff, state_in;
   logic [CW-1:0]       i_ff, i_in;
   logic [AW-1:0]       seg_ff, seg_in;
   logic                single_ff, single_in;
   logic [W-1:0]        t_ff, t_in;
   kfs_pkg::key_type    ka_ff, ka_in;
   kfs_pkg::key_type    kb_ff, kb_in;
   logic                sign_ff, sign_in;
   logic signed [W-1:0] factor_ff, factor_in;
   logic signed [64:0]  prod_ff, prod_in;
   logic [1:0]          c_ff, c_in;
   logic [W-1:0]        rx_ff, rx_in, ry_ff, ry_in, rz_ff, rz_in;
   kfs_pkg::status_type stat_ff, stat_in;
   logic                ov_ff, ov_in;
   logic [W-1:0]        ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;
   kfs_pkg::status_type ost_ff, ost_in;

   logic [NW-1:0]       n_wide;
   logic [CW-1:0]       n_eff;
   logic                wr_en;
   logic [AW-1:0]       rd_addr;
   kfs_pkg::key_type    rd_key;
   logic [KW-1:0]       rd_raw;
   kfs_pkg::div_req_type div_req;
   kfs_pkg::div_rsp_type div_rsp;
   logic [W:0]          dt, sp, dt_mag, sp_mag;
   logic [kfs_pkg::DIVIDEND_W-1:0] q;
   logic signed [W-1:0] comp_a, comp_b;
   logic signed [32:0]  delta;
   logic signed [64:0]  prod_adj;
   logic signed [49:0]  scaled;
   logic signed [49:0]  sum;
   logic [W-1:0]        lerp;
   logic                out_free;

   // key table
   assign wr_en = state_ff == kfs_pkg::ST_IDLE && cmd_valid
                  && cmd.kind == kfs_pkg::KIND_LOAD && cmd.slot_ok;

   kfs_ram #(.WIDTH(KW), .DEPTH(MAX_KEYS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(cmd.slot)),
      .wr_data (cmd.key),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );
   assign rd_key = kfs_pkg::key_type'(rd_raw);

   kfs_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // keys in use, clamped to the table size
   always_comb begin
      n_wide = NW'(key_count);
      if (n_wide > NW'(MAX_KEYS)) begin
         n_eff = CW'(MAX_KEYS);
      end else begin
         n_eff = CW'(n_wide);
      end
   end

   // span and offset, sign and magnitude
   always_comb begin
      dt     = {1'b0, t_ff} - {1'b0, ka_ff.ktime};
      sp     = {1'b0, kb_ff.ktime} - {1'b0, ka_ff.ktime};
      dt_mag = dt[W] ? -dt : dt;
      sp_mag = sp[W] ? -sp : sp;
      q      = div_rsp.quotient;
   end

   // component lerp datapath
   always_comb begin
      case (c_ff)
         2'd0: begin
            comp_a = $signed(ka_ff.x);
            comp_b = $signed(kb_ff.x);
         end
         2'd1: begin
            comp_a = $signed(ka_ff.y);
            comp_b = $signed(kb_ff.y);
         end
         default: begin
            comp_a = $signed(ka_ff.z);
            comp_b = $signed(kb_ff.z);
         end
      endcase
      delta    = 33'(comp_b) - 33'(comp_a);
      prod_adj = prod_ff + (prod_ff[64] ? 65'sd65535 : 65'sd0);
      scaled   = 50'(prod_adj >>> kfs_pkg::FRAC_W);
      sum      = scaled + 50'(comp_a);
      lerp     = kfs_pkg::sat_word(sum);
   end

   assign out_free = !ov_ff || rsp_pop;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      seg_in    = seg_ff;
      single_in = single_ff;
      t_in      = t_ff;
      ka_in     = ka_ff;
      kb_in     = kb_ff;
      sign_in   = sign_ff;
      factor_in = factor_ff;
      prod_in   = prod_ff;
      c_in      = c_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      rz_in     = rz_ff;
      stat_in   = stat_ff;
      ov_in     = ov_ff && !rsp_pop;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      oz_in     = oz_ff;
      ost_in    = ost_ff;
      cmd_pop   = 1'b0;
      rd_addr   = seg_ff;
      div_req.start    = 1'b0;
      div_req.dividend = {dt_mag[W-1:0], {kfs_pkg::FRAC_W{1'b0}}};
      div_req.divisor  = sp_mag[W-1:0];

      case (state_ff)
         kfs_pkg::ST_IDLE: begin
            rd_addr = AW'(1);
            if (cmd_valid) begin
               cmd_pop   = 1'b1;
               t_in      = cmd.key.ktime;
               i_in      = '0;
               seg_in    = '0;
               single_in = 1'b0;
               stat_in   = kfs_pkg::STAT_OK;
               if (cmd.kind == kfs_pkg::KIND_QUERY) begin
                  if (n_eff == CW'(0)) begin
                     rx_in    = '0;
                     ry_in    = '0;
                     rz_in    = '0;
                     stat_in  = kfs_pkg::STAT_EMPTY;
                     state_in = kfs_pkg::ST_EMIT;
                  end else if (n_eff == CW'(1)) begin
                     single_in = 1'b1;
                     state_in  = kfs_pkg::ST_RD_A;
                  end else begin
                     state_in = kfs_pkg::ST_SCAN;
                  end
               end
            end
         end
         // one key time per cycle; the next read is issued while this one compares
         kfs_pkg::ST_SCAN: begin
            rd_addr = AW'(i_ff + CW'(2));
            if (t_ff < rd_key.ktime) begin
               seg_in   = AW'(i_ff);
               state_in = kfs_pkg::ST_RD_A;
            end else if (i_ff == n_eff - CW'(2)) begin
               seg_in   = '0;
               state_in = kfs_pkg::ST_RD_A;
            end else begin
               i_in = i_ff + CW'(1);
            end
         end
         kfs_pkg::ST_RD_A: begin
            rd_addr  = seg_ff;
            state_in = kfs_pkg::ST_RD_B;
         end
         kfs_pkg::ST_RD_B: begin
            rd_addr = AW'(seg_ff + AW'(1));
            ka_in   = rd_key;
            rx_in   = rd_key.x;
            ry_in   = rd_key.y;
            rz_in   = rd_key.z;
            if (single_ff) begin
               state_in = kfs_pkg::ST_EMIT;
            end else begin
               state_in = kfs_pkg::ST_GET_B;
            end
         end
         kfs_pkg::ST_GET_B: begin
            kb_in    = rd_key;
            state_in = kfs_pkg::ST_DIV_GO;
         end
         kfs_pkg::ST_DIV_GO: begin
            if (sp == '0) begin
               stat_in  = kfs_pkg::STAT_ZERO_SPAN;
               state_in = kfs_pkg::ST_EMIT;
            end else begin
               div_req.start = 1'b1;
               sign_in       = dt[W] ^ sp[W];
               state_in      = kfs_pkg::ST_DIV_WAIT;
            end
         end
         // saturate the Q16.16 factor
         kfs_pkg::ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               if (!sign_ff) begin
                  if (q > kfs_pkg::DIVIDEND_W'(32'h7FFF_FFFF)) begin
                     factor_in = 32'sh7FFF_FFFF;
                  end else begin
                     factor_in = $signed(q[W-1:0]);
                  end
               end else begin
                  if (q > kfs_pkg::DIVIDEND_W'(32'h8000_0000)) begin
                     factor_in = 32'sh8000_0000;
                  end else begin
                     factor_in = -$signed(q[W-1:0]);
                  end
               end
               c_in     = 2'd0;
               state_in = kfs_pkg::ST_MUL;
            end
         end
         kfs_pkg::ST_MUL: begin
            prod_in  = 65'(factor_ff) * 65'(delta);
            state_in = kfs_pkg::ST_FIN;
         end
         kfs_pkg::ST_FIN: begin
            case (c_ff)
               2'd0:    rx_in = lerp;
               2'd1:    ry_in = lerp;
               default: rz_in = lerp;
            endcase
            if (c_ff == 2'd2) begin
               state_in = kfs_pkg::ST_EMIT;
            end else begin
               c_in     = c_ff + 2'd1;
               state_in = kfs_pkg::ST_MUL;
            end
         end
         kfs_pkg::ST_EMIT: begin
            if (out_free) begin
               ov_in    = 1'b1;
               ox_in    = rx_ff;
               oy_in    = ry_ff;
               oz_in    = rz_ff;
               ost_in   = stat_ff;
               state_in = kfs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kfs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kfs_pkg::ST_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
      end
      i_ff      <= i_in;
      seg_ff    <= seg_in;
      single_ff <= single_in;
      t_ff      <= t_in;
      ka_ff     <= ka_in;
      kb_ff     <= kb_in;
      sign_ff   <= sign_in;
      factor_ff <= factor_in;
      prod_ff   <= prod_in;
      c_ff      <= c_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
      rz_ff     <= rz_in;
      stat_ff   <= stat_in;
      ox_ff     <= ox_in;
      oy_ff     <= oy_in;
      oz_ff     <= oz_in;
      ost_ff    <= ost_in;
   end

   assign rsp_empty  = !ov_ff;
   assign rsp_out_x  = ox_ff;
   assign rsp_out_y  = oy_ff;
   assign rsp_out_z  = oz_ff;
   assign rsp_status = ost_ff;

endmodule

>>> rtl/keyframe_track_linear_sampler.sv
// Keyframe track sampler: linear interpolation of 3-component keys in Q16.16.
//
// Request channel (req_push / req_full): a load beat writes one key into the
// table slot req_key_slot and gives no result; a query beat gives req_sample_time
// and returns one result beat on the response channel (rsp_empty / rsp_pop).
// csr_wen / csr_wdata write key_count, the number of keys in use; write it only
// while the block is idle.
// A two-beat queue sits between the request side and the worker, so requests
// are taken while the worker is busy or a result waits to be popped.
// Load: the worker writes the key as it takes the beat. Query: the worker takes
// the beat, scans key times one per cycle, reads the two segment ends, starts
// the serial span divider (48 quotient bits, one per cycle), does the three
// multiplies and loads the result register. A zero span skips the divider and
// the multiplies, a single key skips the scan and the span, and an empty track
// goes straight to the result register. The key table's single read port and
// the divider set the query time; a beat may also wait in the queue.
// Reset clears key_count, the queue and the result register; the key table is
// not cleared and must be loaded before it is queried.
// If the receiver does not pop, the result holds and the worker stalls before
// overwriting it; the request queue then fills and req_full rises.
module keyframe_track_linear_sampler #(
   parameter int MAX_KEYS = kfs_pkg::MAX_KEYS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic                        req_kind,
   input  logic [kfs_pkg::SLOT_W-1:0]  req_key_slot,
   input  logic [kfs_pkg::WORD_W-1:0]  req_key_time,
   input  logic [kfs_pkg::WORD_W-1:0]  req_key_x,
   input  logic [kfs_pkg::WORD_W-1:0]  req_key_y,
   input  logic [kfs_pkg::WORD_W-1:0]  req_key_z,
   input  logic [kfs_pkg::WORD_W-1:0]  req_sample_time,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [kfs_pkg::WORD_W-1:0]  rsp_out_x,
   output logic [kfs_pkg::WORD_W-1:0]  rsp_out_y,
   output logic [kfs_pkg::WORD_W-1:0]  rsp_out_z,
   output logic [1:0]                  rsp_status,
   input  logic                        csr_wen,
   input  logic [kfs_pkg::COUNT_W-1:0] csr_wdata
);

   logic [kfs_pkg::COUNT_W-1:0] key_count_ff;
   logic                        cmd_valid;
   kfs_pkg::cmd_type            cmd;
   logic                        cmd_pop;

   // key count register
   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= '0;
      end else if (csr_wen) begin
         key_count_ff <= csr_wdata;
      end
   end

   kfs_front #(.MAX_KEYS(MAX_KEYS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_kind        (req_kind),
      .req_key_slot    (req_key_slot),
      .req_key_time    (req_key_time),
      .req_key_x       (req_key_x),
      .req_key_y       (req_key_y),
      .req_key_z       (req_key_z),
      .req_sample_time (req_sample_time),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   kfs_back #(.MAX_KEYS(MAX_KEYS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .key_count  (key_count_ff),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_out_x  (rsp_out_x),
      .rsp_out_y  (rsp_out_y),
      .rsp_out_z  (rsp_out_z),
      .rsp_status (rsp_status)
   );

endmodule

>>> rtl/kfs_checker.sv
// Port-level checks for the keyframe track sampler, bound to the top level.
module kfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [31:0] rsp_out_x,
   input logic [31:0] rsp_out_y,
   input logic [31:0] rsp_out_z,
   input logic [1:0]  rsp_status
);

   // nothing waits on either side right after reset
   a_reset_clear: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // a result beat that is not popped stays valid and holds its x value and status
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_out_x)
                                 && $stable(rsp_status))
      else $error("stalled result beat changed");

   // status code is one of the defined ones
   a_status: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_status != 2'd3)
      else $error("undefined status");

   // empty track returns zeros
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_status == 2'd2 |->
         rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0)
      else $error("empty track result not zero");

endmodule

bind keyframe_track_linear_sampler kfs_checker u_kfs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_full   (req_full),
   .rsp_empty  (rsp_empty),
   .rsp_pop    (rsp_pop),
   .rsp_out_x  (rsp_out_x),
   .rsp_out_y  (rsp_out_y),
   .rsp_out_z  (rsp_out_z),
   .rsp_status (rsp_status)
);

>>> tb/sv/keyframe_track_linear_sampler_chk.sv
// Checker for the keyframe track sampler: watches both channels, predicts and compares.
module keyframe_track_linear_sampler_chk
   import kfs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic               req_full,
   input  logic               req_kind,
   input  logic [SLOT_W-1:0]  req_key_slot,
   input  logic [WORD_W-1:0]  req_key_time,
   input  logic [WORD_W-1:0]  req_key_x,
   input  logic [WORD_W-1:0]  req_key_y,
   input  logic [WORD_W-1:0]  req_key_z,
   input  logic [WORD_W-1:0]  req_sample_time,
   input  logic               rsp_empty,
   input  logic               rsp_pop,
   input  logic [WORD_W-1:0]  rsp_out_x,
   input  logic [WORD_W-1:0]  rsp_out_y,
   input  logic [WORD_W-1:0]  rsp_out_z,
   input  logic [1:0]         rsp_status,
   input  logic               csr_wen,
   input  logic [COUNT_W-1:0] csr_wdata,
   output int                 pending,
   output int                 fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] z;
      status_type        status;
   } sample_type;

   logic [WORD_W-1:0] track_time [MAX_KEYS_DEF];
   logic [WORD_W-1:0] track_x    [MAX_KEYS_DEF];
   logic [WORD_W-1:0] track_y    [MAX_KEYS_DEF];
   logic [WORD_W-1:0] track_z    [MAX_KEYS_DEF];
   logic [COUNT_W-1:0] keys_used;
   sample_type samples_due [$];

   initial begin
      pending = 0;
      fail_count = 0;
   end

   // clamp to signed 32 bits
   function automatic logic [WORD_W-1:0] clamp32(input longint v);
      if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
      if (v < -64'sh8000_0000) return 32'h8000_0000;
      return v[WORD_W-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] blend(input logic signed [WORD_W-1:0] a,
                                               input logic signed [WORD_W-1:0] b,
                                               input longint f);
      longint d;
      longint s;
      d = longint'(b) - longint'(a);
      s = (f * d) / 65536;
      return clamp32(longint'(a) + s);
   endfunction

   // expected beat for a query at time t
   function automatic sample_type sample_track(input logic [WORD_W-1:0] t);
      sample_type r;
      int n;
      int seg;
      longint span;
      longint f;
      n = (keys_used > MAX_KEYS_DEF) ? MAX_KEYS_DEF : int'(keys_used);
      r = '0;
      if (n == 0) begin
         r.status = STAT_EMPTY;
         return r;
      end
      if (n == 1) begin
         r.x = track_x[0];
         r.y = track_y[0];
         r.z = track_z[0];
         r.status = STAT_OK;
         return r;
      end
      seg = 0;
      for (int i = 0; i + 1 < n; i++) begin
         if (t < track_time[i+1]) begin
            seg = i;
            break;
         end
      end
      span = longint'({32'd0, track_time[seg+1]}) - longint'({32'd0, track_time[seg]});
      if (span == 0) begin
         r.x = track_x[seg];
         r.y = track_y[seg];
         r.z = track_z[seg];
         r.status = STAT_ZERO_SPAN;
         return r;
      end
      f = ((longint'({32'd0, t}) - longint'({32'd0, track_time[seg]})) * 65536) / span;
      f = longint'(signed'(clamp32(f)));
      r.x = blend(track_x[seg], track_x[seg+1], f);
      r.y = blend(track_y[seg], track_y[seg+1], f);
      r.z = blend(track_z[seg], track_z[seg+1], f);
      r.status = STAT_OK;
      return r;
   endfunction

   task automatic report(input string what, input logic [WORD_W-1:0] got,
                         input logic [WORD_W-1:0] want);
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      sample_type e;
      if (reset) begin
         keys_used = '0;
         samples_due.delete();
      end else begin
         // result beat
         if (rsp_pop && !rsp_empty) begin
            if (samples_due.size() == 0) begin
               report("unexpected beat", rsp_out_x, '0);
            end else begin
               e = samples_due.pop_front();
               if (rsp_out_x !== e.x) report("out_x", rsp_out_x, e.x);
               if (rsp_out_y !== e.y) report("out_y", rsp_out_y, e.y);
               if (rsp_out_z !== e.z) report("out_z", rsp_out_z, e.z);
               if (rsp_status !== e.status) report("status", 32'(rsp_status), 32'(e.status));
            end
         end
         if (csr_wen) keys_used = csr_wdata;
         // request beat
         if (req_push && !req_full) begin
            if (kind_type'(req_kind) == KIND_LOAD) begin
               track_time[req_key_slot] = req_key_time;
               track_x[req_key_slot] = req_key_x;
               track_y[req_key_slot] = req_key_y;
               track_z[req_key_slot] = req_key_z;
            end else begin
               samples_due = {samples_due, sample_track(req_sample_time)};
            end
         end
      end
      pending = samples_due.size();
   end

endmodule

>>> tb/sv/keyframe_track_linear_sampler_tb.sv
// Testbench top for the keyframe track sampler: stimulus, clock, reset and verdict.
module keyframe_track_linear_sampler_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import kfs_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic               req_kind = 1'b0;
   logic [SLOT_W-1:0]  req_key_slot = '0;
   logic [WORD_W-1:0]  req_key_time = '0;
   logic [WORD_W-1:0]  req_key_x = '0;
   logic [WORD_W-1:0]  req_key_y = '0;
   logic [WORD_W-1:0]  req_key_z = '0;
   logic [WORD_W-1:0]  req_sample_time = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [WORD_W-1:0]  rsp_out_x;
   logic [WORD_W-1:0]  rsp_out_y;
   logic [WORD_W-1:0]  rsp_out_z;
   logic [1:0]         rsp_status;
   logic               csr_wen = 1'b0;
   logic [COUNT_W-1:0] csr_wdata = '0;
   int                 pending;
   int                 fail_count;
   bit                 calm = 1'b0;
   logic [WORD_W-1:0]  times [MAX_KEYS_DEF];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   keyframe_track_linear_sampler dut (.*);
   keyframe_track_linear_sampler_chk chk (.*);

   // receiver stalls at random
   always @(negedge clock) begin
      rsp_pop <= calm || ($urandom_range(99) >= 11);
   end

   initial begin
      #40ms;
      $display("keyframe_track_linear_sampler_tb NOT OK");
      $finish;
   end

   // one request beat; unused fields carry noise
   task automatic send(input kind_type kind, input logic [SLOT_W-1:0] slot,
                       input logic [WORD_W-1:0] kt, input logic [WORD_W-1:0] x,
                       input logic [WORD_W-1:0] y, input logic [WORD_W-1:0] z,
                       input logic [WORD_W-1:0] st);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 11) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_kind = kind;
      req_key_slot = slot;
      req_key_time = kt;
      req_key_x = x;
      req_key_y = y;
      req_key_z = z;
      req_sample_time = st;
      req_push = 1'b1;
      do @(posedge clock); while (req_full);
   endtask

   task automatic load(input int slot, input logic [WORD_W-1:0] kt,
                       input logic [WORD_W-1:0] x, input logic [WORD_W-1:0] y,
                       input logic [WORD_W-1:0] z);
      send(KIND_LOAD, SLOT_W'(slot), kt, x, y, z, $urandom);
   endtask

   task automatic query(input logic [WORD_W-1:0] t);
      send(KIND_QUERY, SLOT_W'($urandom), $urandom, $urandom, $urandom, $urandom, t);
   endtask

   // drain everything, then write key_count
   task automatic set_count(input int n);
      @(negedge clock);
      req_push = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      csr_wen = 1'b1;
      csr_wdata = COUNT_W'(n);
      @(negedge clock);
      csr_wen = 1'b0;
   endtask

   function automatic logic [WORD_W-1:0] comp_value();
      if ($urandom_range(1)) return $urandom;
      return $urandom_range(32'h0010_0000) - 32'h0008_0000;
   endfunction

   initial begin
      int items;
      int n;
      int mode;
      int phase;
      logic [WORD_W-1:0] t;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty, single key, zero span, extremes, unsorted keys
      set_count(0);
      query(32'h0);
      load(0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      set_count(1);
      query(32'hFFFF_FFFF);
      load(1, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      set_count(2);
      query(32'h0);
      query(32'h1234_5678);
      load(1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      query(32'h0);
      query(32'h8000_0000);
      query(32'hFFFF_FFFF);
      load(0, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'hFFFF_0000);
      load(1, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h7FFF_FFFF);
      query(32'h0);
      query(32'h0002_0000);
      query(32'h0003_0000);
      load(0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      load(1, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      query(32'h0000_0005);
      query(32'h8000_0000);
      load(63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // random phases: fresh track, then queries against it
      items = 0;
      phase = 0;
      while (items < 700) begin
         mode = $urandom_range(99);
         if (mode < 70) n = $urandom_range(2, 8);
         else if (mode < 80) n = $urandom_range(0, 1);
         else if (mode < 95) n = $urandom_range(9, 20);
         else n = MAX_KEYS_DEF;
         calm = (phase >= 4 && phase < 8);
         set_count((n == MAX_KEYS_DEF && $urandom_range(1)) ? $urandom_range(64, 127) : n);
         mode = $urandom_range(99);
         t = $urandom_range(32'h0010_0000);
         for (int i = 0; i < n; i++) begin
            if (mode < 70) t = t + $urandom_range(1, 32'h0010_0000);
            else if (mode < 85) t = t + ($urandom_range(2) == 0 ? 0 : $urandom_range(32'h0001_0000));
            else t = $urandom;
            times[i] = t;
            load(i, t, comp_value(), comp_value(), comp_value());
            items++;
         end
         // stray loads above the track
         repeat ($urandom_range(0, 2)) begin
            load($urandom_range(n, 63), $urandom, $urandom, $urandom, $urandom);
            items++;
         end
         repeat ($urandom_range(5, 20)) begin
            mode = $urandom_range(99);
            if (n == 0 || mode < 10) t = $urandom;
            else if (mode < 15) t = 32'h0;
            else if (mode < 20) t = 32'hFFFF_FFFF;
            else if (mode < 35) t = times[$urandom_range(n - 1)];
            else if (times[n-1] > times[0]) t = times[0] + $urandom_range(times[n-1] - times[0]);
            else t = $urandom;
            query(t);
            items++;
         end
         phase++;
      end

      @(negedge clock);
      req_push = 1'b0;
      calm = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (fail_count == 0) begin
         $display("keyframe_track_linear_sampler_tb OK");
      end else begin
         $display("keyframe_track_linear_sampler_tb NOT OK");
      end
      $finish;
   end

endmodule
